/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands for the RTL that checks itself.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cbez_pkg.sv */
// ---------------------------------------------------------------------------
// cbez_pkg
// Shared types and constants of the cubic Bezier point evaluator.
// ---------------------------------------------------------------------------
package cbez_pkg;

  // Operand chunk of the split multipliers.
  localparam int CHUNK_W = 32;

  // Configuration register index width and map.
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_CTRL_ONE_X = 3'd2,
    REG_CTRL_ONE_Y = 3'd3,
    REG_CTRL_TWO_X = 3'd4,
    REG_CTRL_TWO_Y = 3'd5,
    REG_END_X      = 3'd6,
    REG_END_Y      = 3'd7
  } cbez_reg_e;

  // Load enables of the three stages inside one interpolation lane.
  typedef struct packed {
    logic diff_en;
    logic mul_en;
    logic sum_en;
  } cbez_lerp_en_t;

endpackage

/* rtl/cubic_bezier_point_eval_core.sv */
// ---------------------------------------------------------------------------
// cubic_bezier_point_eval_core
// Cubic Bezier curve point evaluator, fully pipelined, one point per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
// Usage:
//   Load the four control points through the cfg port (cfg_we, cfg_addr,
//   cfg_data) while no beat is in flight. Each slave beat carries one curve
//   parameter t (unsigned Q1.TF, values above 1.0 clamp to 1.0); each master
//   beat returns the curve point (x, y) in the signed coordinate format,
//   rounded to nearest (halves upwards) and saturated.
//   The curve is evaluated by de Casteljau's construction: three levels of
//   exact interpolation, each a diff, multiply and sum stage, so no bits are
//   lost before the final rounding.
// Stages and rate:
//   11 register stages: input, 3 x 3 interpolation stages, output. One beat
//   is taken every cycle unless the full pipe is stalled by m_tready; the
//   interpolation multipliers set the stage timing.
// Reset:
//   Clears all valid bits and sets every control point to zero.
// Stalls:
//   A low m_tready holds the output beat; stages behind it keep filling
//   until every stage holds a beat, and only then does s_tready fall.
// ---------------------------------------------------------------------------
module cubic_bezier_point_eval_core
  import cbez_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration write port
  input  logic                                     cfg_we,
  input  logic [REG_IDX_W-1:0]                     cfg_addr,
  input  logic [COORD_WIDTH-1:0]                   cfg_data,
  // parameter stream
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((T_FRAC_BITS+8)/8)*8-1:0]         s_tdata,  // [TF:0] param_t
  // point stream
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]       m_tdata   // point_x, point_y
);

  localparam int CW  = COORD_WIDTH;
  localparam int TF  = T_FRAC_BITS;
  localparam int TW  = TF + 1;
  localparam int MDW = ((2*CW+7)/8)*8;
  localparam int NS  = 11;          // register stages, input to output
  localparam int W3  = CW + 3*TF;   // width of the final exact sum

  localparam logic [TW-1:0]        T_ONE = TW'(1) << TF;
  localparam logic signed [W3:0]   HALF  = (W3+1)'(1) << (3*TF-1);
  localparam logic signed [CW:0]   MAXV  = {2'b00, {(CW-1){1'b1}}};
  localparam logic signed [CW:0]   MINV  = {2'b11, {(CW-1){1'b0}}};

  // control points: [axis][point], axis 0 is x
  logic signed [CW-1:0] pt [2][4];

  logic [NS-1:0]  v;
  logic [NS-1:0]  en;
  logic [TW-1:0]  t_in;
  logic [TW-1:0]  t_pipe [8];

  cbez_lerp_en_t  lerp_en [3];

  logic signed [CW+TF-1:0]   l1 [2][3];
  logic signed [CW+2*TF-1:0] l2 [2][2];
  logic signed [W3-1:0]      l3 [2];

  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ax = 0; ax < 2; ax++) begin
        for (int p = 0; p < 4; p++) begin
          pt[ax][p] <= '0;
        end
      end
    end else if (cfg_we) begin
      unique case (cbez_reg_e'(cfg_addr))
        REG_START_X:    pt[0][0] <= cfg_data;
        REG_START_Y:    pt[1][0] <= cfg_data;
        REG_CTRL_ONE_X: pt[0][1] <= cfg_data;
        REG_CTRL_ONE_Y: pt[1][1] <= cfg_data;
        REG_CTRL_TWO_X: pt[0][2] <= cfg_data;
        REG_CTRL_TWO_Y: pt[1][2] <= cfg_data;
        REG_END_X:      pt[0][3] <= cfg_data;
        REG_END_Y:      pt[1][3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: a stage may load when it, or anything ahead, has room
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = m_tready | ~(&v[NS-1:k]);
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: clamp t to 1.0, then carry it to each multiply stage
  // ---------------------------------------------------------------------
  assign t_in = s_tdata[TW-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_pipe[0] <= (t_in > T_ONE) ? T_ONE : t_in;
    end
    for (int k = 1; k < 8; k++) begin
      if (en[k]) begin
        t_pipe[k] <= t_pipe[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // de Casteljau levels: 3, 2 and 1 interpolations per axis
  // ---------------------------------------------------------------------
  for (genvar lv = 0; lv < 3; lv++) begin : g_lv_en
    assign lerp_en[lv] = '{diff_en: en[1+3*lv], mul_en: en[2+3*lv], sum_en: en[3+3*lv]};
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    for (genvar i = 0; i < 3; i++) begin : g_lv0
      cbez_lerp #(.AW(CW), .TF(TF)) u_lerp (
        .clk (clk),
        .en  (lerp_en[0]),
        .a   (pt[ax][i]),
        .b   (pt[ax][i+1]),
        .t   (t_pipe[1]),
        .y   (l1[ax][i])
      );
    end
    for (genvar i = 0; i < 2; i++) begin : g_lv1
      cbez_lerp #(.AW(CW+TF), .TF(TF)) u_lerp (
        .clk (clk),
        .en  (lerp_en[1]),
        .a   (l1[ax][i]),
        .b   (l1[ax][i+1]),
        .t   (t_pipe[4]),
        .y   (l2[ax][i])
      );
    end
    cbez_lerp #(.AW(CW+2*TF), .TF(TF)) u_lerp2 (
      .clk (clk),
      .en  (lerp_en[2]),
      .a   (l2[ax][0]),
      .b   (l2[ax][1]),
      .t   (t_pipe[7]),
      .y   (l3[ax])
    );
  end

  // ---------------------------------------------------------------------
  // Output stage: round half up, drop the 3*TF fraction bits, saturate
  // ---------------------------------------------------------------------
  function automatic logic signed [CW-1:0] round_sat(input logic signed [W3-1:0] s);
    logic signed [W3:0] r;
    logic signed [CW:0] q;
    r = (W3+1)'(s) + HALF;
    q = r[W3:3*TF];
    if (q > MAXV) begin
      round_sat = MAXV[CW-1:0];
    end else if (q < MINV) begin
      round_sat = MINV[CW-1:0];
    end else begin
      round_sat = q[CW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      point_x <= round_sat(l3[0]);
      point_y <= round_sat(l3[1]);
    end
  end

  assign m_tdata = MDW'({point_y, point_x});

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_stall_only_when_full, !s_tready, (&v) && !m_tready, "input stalled with room in the pipe")
  `ASSERT_IMPLIES(a_ready_frees_input, m_tready, s_tready, "input stalled while output drains")
  `ASSERT_IMPLIES(a_t_clamped, v[0], t_pipe[0] <= T_ONE, "parameter above one past input stage")
  `ASSERT_NEXT(a_last_beat_lands, v[NS-2] && !m_tvalid, m_tvalid, "beat lost before output register")

endmodule

/* rtl/cbez_lerp.sv */
// ---------------------------------------------------------------------------
// cbez_lerp
// Exact fixed-point interpolation a*(1-t) + b*t, three register stages.
// ---------------------------------------------------------------------------
module cbez_lerp
  import cbez_pkg::*;
#(
  parameter int AW = 16,
  parameter int TF = 16
) (
  input  logic                    clk,
  input  cbez_lerp_en_t           en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [AW-1:0]    b,
  input  logic        [TF:0]      t,
  output logic signed [AW+TF-1:0] y
);

  localparam int DW  = AW + 1;
  localparam int NCH = (DW + CHUNK_W - 1) / CHUNK_W;
  localparam int EW  = NCH * CHUNK_W;
  localparam int TW  = TF + 1;
  localparam int PW  = CHUNK_W + TW + 2;
  localparam int SW  = EW + TF + 2;
  localparam int OW  = AW + TF;

  logic signed [AW-1:0] a_d1;
  logic signed [AW-1:0] a_d2;
  logic signed [DW-1:0] diff;
  logic signed [EW-1:0] dext;
  logic signed [PW-1:0] prod [NCH];
  logic signed [SW-1:0] acc;

  // a*(1-t) + b*t == a*2^TF + (b-a)*t: one product per chunk of the difference
  always_ff @(posedge clk) begin
    if (en.diff_en) begin
      a_d1 <= a;
      diff <= DW'(b) - DW'(a);
    end
  end

  assign dext = EW'(diff);

  // Split the difference into chunks; only the top chunk carries the sign
  for (genvar j = 0; j < NCH; j++) begin : g_chunk
    if (j < NCH - 1) begin : g_low
      always_ff @(posedge clk) begin
        if (en.mul_en) begin
          prod[j] <= $signed({1'b0, dext[j*CHUNK_W +: CHUNK_W]}) * $signed({1'b0, t});
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (en.mul_en) begin
          prod[j] <= $signed(dext[j*CHUNK_W +: CHUNK_W]) * $signed({1'b0, t});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      a_d2 <= a_d1;
    end
  end

  always_comb begin
    acc = SW'(a_d2) <<< TF;
    for (int j = 0; j < NCH; j++) begin
      acc = acc + (SW'(prod[j]) <<< (j * CHUNK_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum_en) begin
      y <= OW'(acc);
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the cubic Bezier point evaluator: curve parameters
// stream in under bursty traffic and random back-pressure, and every point
// beat is checked against an exact fixed-point evaluation of the curve.
// ---------------------------------------------------------------------------
module tb
  import cbez_pkg::*;
();

  localparam int COORD_W   = 16;
  localparam int T_FRAC    = 16;
  localparam int S_W       = ((T_FRAC + 8) / 8) * 8;
  localparam int M_W       = ((2 * COORD_W + 7) / 8) * 8;
  localparam int LATENCY   = 10;
  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_W - 1));
  localparam int RX_REPORT = 10;

  localparam logic [T_FRAC:0] T_ONE_PARAM = (T_FRAC + 1)'(1) << T_FRAC;

  typedef logic signed [127:0] exact_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  logic               clk;
  logic               rst      = 1'b1;
  logic               cfg_we   = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr = REG_START_X;
  logic [COORD_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [S_W-1:0]     s_tdata  = '0;  // [16:0] param_t, rest zero
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [M_W-1:0]     m_tdata;        // [15:0] point_x, [31:16] point_y

  // Bench copy of the control-point registers, indexed by register code.
  logic [COORD_W-1:0] coord_reg [8];

  logic [S_W-1:0] pending_params [$];
  point_t         expected_points [$];

  int points_due;
  int points_seen;
  int params_taken;
  int above_one_count;
  int curve_settings;
  int mismatches;

  // Sender burst shaping.
  int burst_left;
  int gap_left;

  // Receiver stall shaping.
  int rx_cycle;
  int rx_mode;
  int hold_left;
  bit long_hold_done;

  point_t want;

  cubic_bezier_point_eval_core #(
    .COORD_WIDTH (COORD_W),
    .T_FRAC_BITS (T_FRAC)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Weighted sum of one axis: exact products, add one half, floor, saturate.
  // Halves therefore round towards plus infinity.
  function automatic logic [COORD_W-1:0] blend_axis(logic [3:0][127:0] wt, int axis);
    exact_t             acc;
    exact_t             cw;
    exact_t             half;
    exact_t             q;
    logic signed [COORD_W-1:0] c;
    acc  = '0;
    half = exact_t'(1);
    half = half <<< (3 * T_FRAC - 1);
    for (int i = 0; i < 4; i++) begin
      c   = coord_reg[axis + 2 * i];
      cw  = exact_t'(c);
      acc = acc + $signed(wt[i]) * cw;
    end
    q = (acc + half) >>> (3 * T_FRAC);
    if (q > COORD_MAX) begin
      q = exact_t'(COORD_MAX);
    end else if (q < COORD_MIN) begin
      q = exact_t'(COORD_MIN);
    end
    return q[COORD_W-1:0];
  endfunction

  // Point on the curve for one parameter; Bernstein weights scaled by 2^48.
  function automatic point_t predict_point(logic [T_FRAC:0] t_raw);
    logic [127:0]     tv;
    logic [127:0]     uv;
    logic [3:0][127:0] wt;
    point_t           p;
    tv    = 128'((t_raw > T_ONE_PARAM) ? T_ONE_PARAM : t_raw);
    uv    = 128'(T_ONE_PARAM) - tv;
    wt[0] = uv * uv * uv;
    wt[1] = 3 * uv * uv * tv;
    wt[2] = 3 * tv * tv * uv;
    wt[3] = tv * tv * tv;
    p.x   = blend_axis(wt, 0);
    p.y   = blend_axis(wt, 1);
    return p;
  endfunction

  // Driver: bursts of random length, random gaps; valid and data held on stall.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_points.push_back(predict_point(s_tdata[T_FRAC:0]));
        params_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_params.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_params.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
          end
          burst_left--;
          // A quarter of bursts run straight into the next one.
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each point beat, then pick the next ready value.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_cycle  = 0;
      rx_mode   = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= RX_REPORT) begin
            $display("point beat with nothing expected: x=%0d y=%0d",
                     $signed(m_tdata[COORD_W-1:0]),
                     $signed(m_tdata[2*COORD_W-1:COORD_W]));
          end
        end else begin
          want = expected_points.pop_front();
          if (m_tdata[COORD_W-1:0] !== want.x ||
              m_tdata[2*COORD_W-1:COORD_W] !== want.y) begin
            mismatches++;
            if (mismatches <= RX_REPORT) begin
              $display("point %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                       points_seen, $signed(want.x), $signed(want.y),
                       $signed(m_tdata[COORD_W-1:0]),
                       $signed(m_tdata[2*COORD_W-1:COORD_W]));
            end
          end
        end
        points_seen++;
      end

      rx_cycle++;
      if (rx_cycle % 97 == 0) begin
        rx_mode = $urandom_range(0, 3);
      end
      // Hold off once for a long stretch so the pipe fills and s_tready drops.
      if (!long_hold_done && points_seen >= 245) begin
        hold_left      = 120;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: begin
            m_tready <= 1'b1;
          end
          1: begin
            m_tready <= ($urandom_range(0, 3) != 0);
          end
          2: begin
            m_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_tready <= rx_cycle[0];
          end
        endcase
      end
    end
  end

  task automatic write_coord(cbez_reg_e idx, logic [COORD_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    coord_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_curve(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                           logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                           logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
                           logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
    write_coord(REG_START_X, sx);
    write_coord(REG_START_Y, sy);
    write_coord(REG_CTRL_ONE_X, ax);
    write_coord(REG_CTRL_ONE_Y, ay);
    write_coord(REG_CTRL_TWO_X, bx);
    write_coord(REG_CTRL_TWO_Y, by);
    write_coord(REG_END_X, ex);
    write_coord(REG_END_Y, ey);
    curve_settings++;
  endtask

  task automatic queue_param(logic [T_FRAC:0] t);
    pending_params.push_back(S_W'(t));
    points_due++;
    if (t > T_ONE_PARAM) begin
      above_one_count++;
    end
  endtask

  // Block the caller until every queued parameter has come back as a point.
  task automatic drain_points();
    while (points_seen < points_due) begin
      @(posedge clk);
    end
  endtask

  // Mostly inside [0, 1], with the ends and the clamped range well visited.
  function automatic logic [T_FRAC:0] random_param();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return T_ONE_PARAM;
      2, 3:    return (T_FRAC + 1)'($urandom_range(int'(T_ONE_PARAM) + 1,
                                                   2 ** (T_FRAC + 1) - 1));
      default: return (T_FRAC + 1)'($urandom_range(0, int'(T_ONE_PARAM)));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 5))
      0:       return COORD_W'(COORD_MIN);
      1:       return COORD_W'(COORD_MAX);
      2:       return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  initial begin
    for (int i = 0; i < 8; i++) begin
      coord_reg[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset values: every control point at the origin.
    queue_param(T_ONE_PARAM >> 1);
    queue_param('1);
    drain_points();

    // Rounding ties at t = 0.5: x lands on +0.5 LSB, y on -0.5 LSB.
    set_curve(16'd4, -16'sd4, '0, '0, '0, '0, '0, '0);
    queue_param(T_ONE_PARAM >> 1);
    queue_param('0);
    queue_param(T_ONE_PARAM);
    drain_points();

    // Extreme control points, parameter extremes and clamping above one.
    set_curve(COORD_W'(COORD_MIN), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX),
              COORD_W'(COORD_MIN), COORD_W'(COORD_MIN), COORD_W'(COORD_MAX),
              COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
    queue_param('0);
    queue_param((T_FRAC + 1)'(1));
    queue_param((T_FRAC + 1)'(T_ONE_PARAM - 1));
    queue_param(T_ONE_PARAM);
    queue_param((T_FRAC + 1)'(T_ONE_PARAM + 1));
    queue_param('1);
    queue_param(T_ONE_PARAM >> 1);
    queue_param(T_ONE_PARAM >> 2);
    queue_param((T_FRAC + 1)'(3 * (T_ONE_PARAM >> 2)));
    queue_param(17'h0aaaa);
    queue_param(17'h15555);
    drain_points();

    // Random phases; the first two pin every point to one rail.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          set_curve(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX),
                    COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX),
                    COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
        end
        1: begin
          set_curve(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN), COORD_W'(COORD_MIN),
                    COORD_W'(COORD_MIN), COORD_W'(COORD_MIN), COORD_W'(COORD_MIN),
                    COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
        end
        default: begin
          set_curve(random_coord(), random_coord(), random_coord(), random_coord(),
                    random_coord(), random_coord(), random_coord(), random_coord());
        end
      endcase
      for (int n = 0; n < 90; n++) begin
        queue_param(random_param());
      end
      drain_points();
    end

    // Let any stray beat show up before the verdict.
    repeat (LATENCY + 8) @(posedge clk);
    mismatches += expected_points.size();

    $display("Evaluated %0d curve parameters (%0d above one) across %0d point settings,",
             params_taken, above_one_count, curve_settings);
    $display("with bursty input, random output stalls and one long hold; %0d beats checked.",
             points_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
